FILE: design/hlmdu_pkg.sv
// shared types and constants of the hi/lo multiply-divide unit
package hlmdu_pkg;

   localparam int WORD_W    = 32;
   localparam int DIV_STEPS = WORD_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   typedef logic [2:0] mode_type;

   localparam mode_type MODE_SMUL  = 3'd0;
   localparam mode_type MODE_UMUL  = 3'd1;
   localparam mode_type MODE_SDIV  = 3'd2;
   localparam mode_type MODE_UDIV  = 3'd3;
   localparam mode_type MODE_SMADD = 3'd4;
   localparam mode_type MODE_UMADD = 3'd5;

   typedef struct packed {
      logic load;      // capture a new transaction
      logic mul;       // form the product
      logic acc;       // finish multiply, madd or no-op
      logic div_step;  // one restoring divide step
      logic fix;       // apply signs to quotient and remainder
   } cmd_type;

endpackage

FILE: design/hlmdu_ctrl.sv
// controller state machine of the hi/lo multiply-divide unit
module hlmdu_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  hlmdu_pkg::mode_type req_mode,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output hlmdu_pkg::cmd_type  cmd
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_MUL  = 6'b000010,
      ST_ACC  = 6'b000100,
      ST_DIV  = 6'b001000,
      ST_FIX  = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

   state_type                  state_ff, state_in;
   logic [hlmdu_pkg::CNT_W-1:0] count_ff, count_in;
   logic                       is_div;
   logic                       last_step;

   assign is_div    = (req_mode == hlmdu_pkg::MODE_SDIV) || (req_mode == hlmdu_pkg::MODE_UDIV);
   assign last_step = (count_ff == hlmdu_pkg::CNT_W'(hlmdu_pkg::DIV_STEPS - 1));

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               count_in = '0;
               state_in = is_div ? ST_DIV : ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = ST_DONE;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            count_in     = count_ff + 1'b1;
            if (last_step) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            cmd.fix  = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

endmodule

FILE: design/hlmdu_dp.sv
// datapath of the hi/lo multiply-divide unit: operands, multiplier, divider, hi/lo pairs
module hlmdu_dp (
   input  logic                clock,
   input  logic                reset,
   input  hlmdu_pkg::cmd_type  cmd,
   input  hlmdu_pkg::mode_type req_mode,
   input  logic                req_pipe_sel,
   input  logic [31:0]         req_src_a,
   input  logic [31:0]         req_src_b,
   output logic [31:0]         rsp_lo_word,
   output logic [31:0]         rsp_hi_word,
   output logic                rsp_dest_write
);

   logic [31:0] lo_regs_ff [2];
   logic [31:0] hi_regs_ff [2];

   hlmdu_pkg::mode_type mode_ff;
   logic        sel_ff;
   logic [31:0] a_ff, b_ff;
   logic [63:0] prod_ff;
   logic [31:0] quo_ff, rem_ff, dvs_ff;
   logic        neg_q_ff, neg_r_ff;
   logic [31:0] lo_out_ff, hi_out_ff;
   logic        dw_out_ff;

   logic        sdiv;
   logic        na, nb;
   logic        mul_signed;
   logic [63:0] prod_full;
   logic [63:0] cur_pair;
   logic [63:0] acc_res;
   logic        acc_dw;
   logic [32:0] shifted;
   logic [32:0] diff;
   logic [31:0] fix_q, fix_r;

   assign sdiv = (req_mode == hlmdu_pkg::MODE_SDIV);
   assign na   = sdiv & req_src_a[31];
   assign nb   = sdiv & req_src_b[31];

   assign mul_signed = (mode_ff == hlmdu_pkg::MODE_SMUL) || (mode_ff == hlmdu_pkg::MODE_SMADD);
   assign prod_full  = 64'($signed({mul_signed & a_ff[31], a_ff}) *
                           $signed({mul_signed & b_ff[31], b_ff}));

   assign cur_pair = {hi_regs_ff[sel_ff], lo_regs_ff[sel_ff]};

   always_comb begin
      acc_res = cur_pair;
      acc_dw  = 1'b0;
      priority if ((mode_ff == hlmdu_pkg::MODE_SMUL) || (mode_ff == hlmdu_pkg::MODE_UMUL)) begin
         acc_res = prod_ff;
         acc_dw  = 1'b1;
      end else if ((mode_ff == hlmdu_pkg::MODE_SMADD) || (mode_ff == hlmdu_pkg::MODE_UMADD)) begin
         acc_res = prod_ff + cur_pair;
         acc_dw  = 1'b1;
      end else begin
         // unused codes leave the pair as it is
         acc_res = cur_pair;
         acc_dw  = 1'b0;
      end
   end

   // restoring step on magnitudes; a zero divisor yields all-ones quotient naturally
   assign shifted = {rem_ff, quo_ff[31]};
   assign diff    = shifted - {1'b0, dvs_ff};

   assign fix_q = neg_q_ff ? (32'd0 - quo_ff) : quo_ff;
   assign fix_r = neg_r_ff ? (32'd0 - rem_ff) : rem_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff  <= req_mode;
         sel_ff   <= req_pipe_sel;
         a_ff     <= req_src_a;
         b_ff     <= req_src_b;
         quo_ff   <= na ? (32'd0 - req_src_a) : req_src_a;
         dvs_ff   <= nb ? (32'd0 - req_src_b) : req_src_b;
         rem_ff   <= '0;
         neg_q_ff <= na ^ nb;
         neg_r_ff <= na;
      end
      if (cmd.mul) begin
         prod_ff <= prod_full;
      end
      if (cmd.div_step) begin
         if (!diff[32]) begin
            rem_ff <= diff[31:0];
            quo_ff <= {quo_ff[30:0], 1'b1};
         end else begin
            rem_ff <= shifted[31:0];
            quo_ff <= {quo_ff[30:0], 1'b0};
         end
      end
      if (cmd.acc) begin
         lo_out_ff <= acc_res[31:0];
         hi_out_ff <= acc_res[63:32];
         dw_out_ff <= acc_dw;
      end else if (cmd.fix) begin
         lo_out_ff <= fix_q;
         hi_out_ff <= fix_r;
         dw_out_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_regs_ff[0] <= '0;
         lo_regs_ff[1] <= '0;
         hi_regs_ff[0] <= '0;
         hi_regs_ff[1] <= '0;
      end else if (cmd.acc) begin
         lo_regs_ff[sel_ff] <= acc_res[31:0];
         hi_regs_ff[sel_ff] <= acc_res[63:32];
      end else if (cmd.fix) begin
         lo_regs_ff[sel_ff] <= fix_q;
         hi_regs_ff[sel_ff] <= fix_r;
      end
   end

   assign rsp_lo_word    = lo_out_ff;
   assign rsp_hi_word    = hi_out_ff;
   assign rsp_dest_write = dw_out_ff;

endmodule

FILE: design/hi_lo_multiply_divide_unit_top.sv
// top level of the hi/lo multiply-divide unit
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_ready  mode, pipe_sel, src_a, src_b
//   rsp_      out        rsp_valid/rsp_ready  lo_word, hi_word, dest_write
//
// one transaction at a time; req_ready is high only while the unit is empty
// multiply, madd and unused codes: product in ST_MUL, then 64-bit add in ST_ACC, then rsp_valid
// divide: 32 radix-2 restoring steps in ST_DIV, then the sign fix in ST_FIX, then rsp_valid
// rsp_valid holds with the result until rsp_ready; the next transaction is taken after that
// synchronous reset empties the unit and clears both lo/hi pairs
module hi_lo_multiply_divide_unit_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_mode,
   input  logic        req_pipe_sel,
   input  logic [31:0] req_src_a,
   input  logic [31:0] req_src_b,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_lo_word,
   output logic [31:0] rsp_hi_word,
   output logic        rsp_dest_write
);

   hlmdu_pkg::cmd_type cmd;

   hlmdu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   hlmdu_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_mode       (req_mode),
      .req_pipe_sel   (req_pipe_sel),
      .req_src_a      (req_src_a),
      .req_src_b      (req_src_b),
      .rsp_lo_word    (rsp_lo_word),
      .rsp_hi_word    (rsp_hi_word),
      .rsp_dest_write (rsp_dest_write)
   );

endmodule

FILE: dv/testbench.sv
// self-checking testbench for the hi/lo multiply-divide unit
`timescale 1ns / 100ps

module testbench;

   localparam hlmdu_pkg::mode_type MODE_UNUSED6 = 3'd6;
   localparam hlmdu_pkg::mode_type MODE_UNUSED7 = 3'd7;
   localparam logic [31:0] SIGN_WORD = 32'h8000_0000;
   localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;
   localparam int RANDOM_PER_PHASE   = 150;
   localparam int DRAIN_CYCLES       = 40;
   localparam int HOLD_CYCLES        = 400;

   typedef struct packed {
      logic [31:0] lo;
      logic [31:0] hi;
      logic        dw;
   } hilo_result_type;

   typedef struct packed {
      hlmdu_pkg::mode_type mode;
      logic                sel;
      logic [31:0]         a;
      logic [31:0]         b;
      logic                typed;
      logic [31:0]         lo;
      logic [31:0]         hi;
      logic                dw;
   } vec_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   hlmdu_pkg::mode_type req_mode = hlmdu_pkg::MODE_SMUL;
   logic                req_pipe_sel = 1'b0;
   logic [31:0]         req_src_a = '0;
   logic [31:0]         req_src_b = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [31:0]         rsp_lo_word;
   logic [31:0]         rsp_hi_word;
   logic                rsp_dest_write;

   // expectation typed into the table travels with the transaction
   logic            req_has_typed = 1'b0;
   hilo_result_type req_typed = '0;

   logic [31:0]     lo_state [2];
   logic [31:0]     hi_state [2];
   hilo_result_type pending_hilo [$];
   int              fail_count = 0;
   int              tx_idle_pct = 18;
   int              rx_idle_pct = 79;
   logic            hold_req = 1'b0;
   logic            hold_taken = 1'b0;
   int              hold_left = 0;

   vec_row_type directed_rows [25] = '{
      '{hlmdu_pkg::MODE_SMUL,  1'b0, 32'h0000_0000, 32'h0000_0000,
        1'b1, 32'h0000_0000, 32'h0000_0000, 1'b1},
      '{hlmdu_pkg::MODE_SMUL,  1'b1, ALL_ONES,      ALL_ONES,
        1'b1, 32'h0000_0001, 32'h0000_0000, 1'b1},
      '{hlmdu_pkg::MODE_UMUL,  1'b0, ALL_ONES,      ALL_ONES,
        1'b1, 32'h0000_0001, 32'hFFFF_FFFE, 1'b1},
      '{hlmdu_pkg::MODE_SMUL,  1'b1, SIGN_WORD,     SIGN_WORD,
        1'b1, 32'h0000_0000, 32'h4000_0000, 1'b1},
      '{hlmdu_pkg::MODE_SMUL,  1'b0, 32'h7FFF_FFFF, SIGN_WORD,     1'b0, '0, '0, 1'b0},
      '{hlmdu_pkg::MODE_UMUL,  1'b1, SIGN_WORD,     32'h0000_0002,
        1'b1, 32'h0000_0000, 32'h0000_0001, 1'b1},
      '{hlmdu_pkg::MODE_SMADD, 1'b0, ALL_ONES,      32'h0000_0001, 1'b0, '0, '0, 1'b0},
      '{hlmdu_pkg::MODE_UMADD, 1'b1, ALL_ONES,      ALL_ONES,      1'b0, '0, '0, 1'b0},
      '{hlmdu_pkg::MODE_UMADD, 1'b1, ALL_ONES,      ALL_ONES,      1'b0, '0, '0, 1'b0},
      '{hlmdu_pkg::MODE_SMADD, 1'b0, SIGN_WORD,     SIGN_WORD,     1'b0, '0, '0, 1'b0},
      '{hlmdu_pkg::MODE_SMADD, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0, '0, 1'b0},
      '{MODE_UNUSED6,          1'b0, 32'hDEAD_BEEF, 32'h1234_5678, 1'b0, '0, '0, 1'b0},
      '{MODE_UNUSED7,          1'b1, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 1'b0, '0, '0, 1'b0},
      '{hlmdu_pkg::MODE_SDIV,  1'b1, SIGN_WORD,     ALL_ONES,
        1'b1, SIGN_WORD,     32'h0000_0000, 1'b0},
      '{hlmdu_pkg::MODE_SDIV,  1'b0, SIGN_WORD,     32'h0000_0000,
        1'b1, 32'h0000_0001, SIGN_WORD,     1'b0},
      '{hlmdu_pkg::MODE_SDIV,  1'b1, 32'h0000_0005, 32'h0000_0000,
        1'b1, ALL_ONES,      32'h0000_0005, 1'b0},
      '{hlmdu_pkg::MODE_SDIV,  1'b0, 32'h0000_0000, 32'h0000_0000,
        1'b1, ALL_ONES,      32'h0000_0000, 1'b0},
      '{hlmdu_pkg::MODE_UDIV,  1'b1, 32'h1234_5678, 32'h0000_0000,
        1'b1, ALL_ONES,      32'h1234_5678, 1'b0},
      '{hlmdu_pkg::MODE_UDIV,  1'b0, ALL_ONES,      32'h0000_0001,
        1'b1, ALL_ONES,      32'h0000_0000, 1'b0},
      '{hlmdu_pkg::MODE_UDIV,  1'b1, 32'h0000_0001, ALL_ONES,
        1'b1, 32'h0000_0000, 32'h0000_0001, 1'b0},
      '{hlmdu_pkg::MODE_SDIV,  1'b0, 32'hFFFF_FFF9, 32'h0000_0002, 1'b0, '0, '0, 1'b0},
      '{hlmdu_pkg::MODE_SDIV,  1'b1, 32'h0000_0007, 32'hFFFF_FFFE, 1'b0, '0, '0, 1'b0},
      '{hlmdu_pkg::MODE_SDIV,  1'b0, SIGN_WORD,     32'h0000_0001,
        1'b1, SIGN_WORD,     32'h0000_0000, 1'b0},
      '{hlmdu_pkg::MODE_SDIV,  1'b1, ALL_ONES,      SIGN_WORD,     1'b0, '0, '0, 1'b0},
      '{hlmdu_pkg::MODE_UMADD, 1'b0, 32'h0000_0000, 32'h0000_0000, 1'b0, '0, '0, 1'b0}
   };

   hi_lo_multiply_divide_unit_top uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_pipe_sel   (req_pipe_sel),
      .req_src_a      (req_src_a),
      .req_src_b      (req_src_b),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_lo_word    (rsp_lo_word),
      .rsp_hi_word    (rsp_hi_word),
      .rsp_dest_write (rsp_dest_write)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // updates the lo/hi pair the way the unit should and returns the new pair
   task automatic apply_hilo_op(input hlmdu_pkg::mode_type m, input logic sel,
                                input logic [31:0] a, input logic [31:0] b,
                                output hilo_result_type res);
      logic [63:0] ea;
      logic [63:0] eb;
      logic [63:0] acc;
      logic [31:0] ma;
      logic [31:0] mb;
      logic [31:0] mq;
      logic [31:0] mr;
      res.lo = lo_state[sel];
      res.hi = hi_state[sel];
      res.dw = 1'b0;
      case (m)
         hlmdu_pkg::MODE_SMUL, hlmdu_pkg::MODE_UMUL,
         hlmdu_pkg::MODE_SMADD, hlmdu_pkg::MODE_UMADD: begin
            if (m == hlmdu_pkg::MODE_SMUL || m == hlmdu_pkg::MODE_SMADD) begin
               ea = {{32{a[31]}}, a};
               eb = {{32{b[31]}}, b};
            end else begin
               ea = {32'b0, a};
               eb = {32'b0, b};
            end
            acc = ea * eb;
            // madd wraps modulo 2^64
            if (m == hlmdu_pkg::MODE_SMADD || m == hlmdu_pkg::MODE_UMADD)
               acc = acc + {res.hi, res.lo};
            res.lo = acc[31:0];
            res.hi = acc[63:32];
            res.dw = 1'b1;
         end
         hlmdu_pkg::MODE_SDIV: begin
            if (a == SIGN_WORD && b == ALL_ONES) begin
               res.lo = SIGN_WORD;
               res.hi = '0;
            end else if (b == '0) begin
               res.lo = a[31] ? 32'h0000_0001 : ALL_ONES;
               res.hi = a;
            end else begin
               ma = a[31] ? -a : a;
               mb = b[31] ? -b : b;
               mq = ma / mb;
               mr = ma % mb;
               res.lo = (a[31] ^ b[31]) ? -mq : mq;
               res.hi = a[31] ? -mr : mr;
            end
         end
         hlmdu_pkg::MODE_UDIV: begin
            if (b == '0) begin
               res.lo = ALL_ONES;
               res.hi = a;
            end else begin
               res.lo = a / b;
               res.hi = a % b;
            end
         end
         default: ;
      endcase
      lo_state[sel] = res.lo;
      hi_state[sel] = res.hi;
   endtask

   // result side first; a result and a new accept never share an edge
   always @(posedge clock) begin
      hilo_result_type want;
      hilo_result_type predicted;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_hilo.size() == 0) begin
            $display("%0t: result with nothing expected, lo %h hi %h dw %b",
                     $time, rsp_lo_word, rsp_hi_word, rsp_dest_write);
            fail_count++;
         end else begin
            want = pending_hilo.pop_front();
            if (rsp_lo_word !== want.lo) begin
               $display("%0t: lo_word mismatch, expected %h, actual %h",
                        $time, want.lo, rsp_lo_word);
               fail_count++;
            end
            if (rsp_hi_word !== want.hi) begin
               $display("%0t: hi_word mismatch, expected %h, actual %h",
                        $time, want.hi, rsp_hi_word);
               fail_count++;
            end
            if (rsp_dest_write !== want.dw) begin
               $display("%0t: dest_write mismatch, expected %b, actual %b",
                        $time, want.dw, rsp_dest_write);
               fail_count++;
            end
         end
      end
      if (!reset && req_valid && req_ready) begin
         apply_hilo_op(req_mode, req_pipe_sel, req_src_a, req_src_b, predicted);
         pending_hilo.push_back(req_has_typed ? req_typed : predicted);
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_req && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_ready  <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   task automatic send_transaction(input hlmdu_pkg::mode_type m, input logic sel,
                                   input logic [31:0] a, input logic [31:0] b,
                                   input logic typed, input hilo_result_type typed_res);
      // gaps up to past a full divide so they land on every phase of it
      if ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
      req_mode      <= m;
      req_pipe_sel  <= sel;
      req_src_a     <= a;
      req_src_b     <= b;
      req_has_typed <= typed;
      req_typed     <= typed_res;
      req_valid     <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   function automatic logic [31:0] operand_word();
      case ($urandom_range(9))
         0: return 32'h0000_0000;
         1: return 32'h0000_0001;
         2: return ALL_ONES;
         3: return SIGN_WORD;
         4: return 32'h7FFF_FFFF;
         5: return $urandom_range(0, 15);
         6: return -$urandom_range(1, 15);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int                  phase;
      int                  n;
      hlmdu_pkg::mode_type m;
      lo_state[0] = '0;
      lo_state[1] = '0;
      hi_state[0] = '0;
      hi_state[1] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_transaction(directed_rows[i].mode, directed_rows[i].sel,
                          directed_rows[i].a, directed_rows[i].b, directed_rows[i].typed,
                          {directed_rows[i].lo, directed_rows[i].hi, directed_rows[i].dw});

      for (phase = 0; phase < 3; phase++) begin
         if (phase == 1) begin
            tx_idle_pct = 79;
            rx_idle_pct = 18;
         end else if (phase == 2) begin
            // let the unit drain fully, then stall the receiver while offering
            req_valid <= 1'b0;
            // the last accepted transaction is queued by the monitor at the accept edge
            @(posedge clock);
            while (pending_hilo.size() != 0) @(posedge clock);
            tx_idle_pct = 0;
            rx_idle_pct = 0;
            hold_req <= 1'b1;
         end
         for (n = 0; n < RANDOM_PER_PHASE; n++) begin
            if ($urandom_range(99) < 3)
               m = $urandom_range(0, 1) ? MODE_UNUSED7 : MODE_UNUSED6;
            else
               m = hlmdu_pkg::mode_type'($urandom_range(0, 5));
            send_transaction(m, 1'($urandom_range(0, 1)), operand_word(), operand_word(),
                             1'b0, '0);
         end
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending_hilo.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("hi_lo_multiply_divide_unit_top verification clean");
      else
         $display("hi_lo_multiply_divide_unit_top verification failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("%0t: timeout", $time);
      $display("hi_lo_multiply_divide_unit_top verification failed");
      $finish;
   end

endmodule

FILE: sim.f
design/hlmdu_pkg.sv
design/hlmdu_ctrl.sv
design/hlmdu_dp.sv
design/hi_lo_multiply_divide_unit_top.sv
dv/testbench.sv
